// File: src/fssf_pkg.sv
// ============================================================================
// fssf_pkg
// Shared types and constants of the frame SNR subtraction factors unit.
// ============================================================================
`default_nettype none

package fssf_pkg;

    localparam int SUM_W   = 42;
    localparam int DEN_W   = SUM_W + 1;
    localparam int GAIN_W  = 16;
    localparam int PWR_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int LOG_W   = 22;
    localparam int FRAC_W  = 16;
    localparam int MANT_W  = 31;
    localparam int SNR_W   = 24;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Decibels per octave of power in Q.16: round(10*log10(2) * 2^16).
    localparam logic [17:0] DB_PER_LOG2 = 18'd197283;
    localparam logic [SNR_W-1:0] TWENTY_DB = 24'd1310720;
    // Reciprocal of 5 with 22 fraction bits, exact for the 19-bit quarter SNR.
    localparam logic [19:0] DIV5_MAGIC = 20'd838861;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALING_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSUB_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDERSUB_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_FLOOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_EPSILON = 3'd5;

    typedef struct packed {
        logic              scaling_mode;
        logic [GAIN_W-1:0] oversub_gain;
        logic [GAIN_W-1:0] undersub_gain;
        logic [GAIN_W-1:0] alpha_floor;
        logic [GAIN_W-1:0] beta_floor;
        logic [GAIN_W-1:0] noise_epsilon;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] noisy;
        logic [DEN_W-1:0] den;
    } t_frame;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_DIFF,
        ST_SCALE,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: src/frame_snr_subtraction_factors_unit.sv
// ============================================================================
// frame_snr_subtraction_factors_unit
// Frame a posteriori SNR over- and undersubtraction factor generator.
// ============================================================================
// Bins are taken one per cycle and added into saturating 42-bit frame sums.
// The bin flagged last closes the frame; its sums enter a two-entry queue and
// the SNR engine turns them into one Q8.8 alpha/beta pair. The engine leaves
// idle, then for each operand normalizes it one bit at a time and runs the
// squaring log2 unit, then scales and blends and loads the output register.
// No-scaling mode, a zero noisy sum or a zero denominator decides the result
// at once. Input is stalled only while both queue entries hold frames.
// Configuration registers are written through the plain write port; the
// user must write them only while the block is idle, which the block itself
// does not enforce.
// ============================================================================
`default_nettype none

module frame_snr_subtraction_factors_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [fssf_pkg::PWR_W-1:0]       i_noisy_power,
    input  wire [fssf_pkg::PWR_W-1:0]       i_noise_power,
    input  wire                             i_last_bin,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [fssf_pkg::GAIN_W-1:0]     o_alpha_factor,
    output logic [fssf_pkg::GAIN_W-1:0]     o_beta_factor,
    input  wire                             i_cfg_we,
    input  wire [fssf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [fssf_pkg::GAIN_W-1:0]      i_cfg_data
);
    import fssf_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_frame w_push_frame, w_pop_frame;
    logic   w_push, w_pop, w_full, w_empty;

    assign o_in_stall = w_full;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALING_MODE:  n_cfg.scaling_mode  = i_cfg_data[0];
                CFG_OVERSUB_GAIN:  n_cfg.oversub_gain  = i_cfg_data;
                CFG_UNDERSUB_GAIN: n_cfg.undersub_gain = i_cfg_data;
                CFG_ALPHA_FLOOR:   n_cfg.alpha_floor   = i_cfg_data;
                CFG_BETA_FLOOR:    n_cfg.beta_floor    = i_cfg_data;
                CFG_NOISE_EPSILON: n_cfg.noise_epsilon = i_cfg_data;
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scaling_mode  <= 1'b0;
            r_cfg.oversub_gain  <= 16'd512;
            r_cfg.undersub_gain <= 16'd256;
            r_cfg.alpha_floor   <= 16'd256;
            r_cfg.beta_floor    <= 16'd0;
            r_cfg.noise_epsilon <= 16'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    fssf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .i_full          (w_full),
        .i_noisy_power   (i_noisy_power),
        .i_noise_power   (i_noise_power),
        .i_last_bin      (i_last_bin),
        .i_noise_epsilon (r_cfg.noise_epsilon),
        .o_push          (w_push),
        .o_frame         (w_push_frame)
    );

    fssf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_frame (w_pop_frame)
    );

    fssf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (w_empty),
        .i_frame        (w_pop_frame),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_alpha_factor (o_alpha_factor),
        .o_beta_factor  (o_beta_factor)
    );

endmodule

`default_nettype wire

// File: src/fssf_front.sv
// ============================================================================
// fssf_front
// Accumulates the saturating noisy and noise frame sums and hands each closed
// frame to the queue.
// ============================================================================
`default_nettype none

module fssf_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire                     i_full,
    input  wire [fssf_pkg::PWR_W-1:0]  i_noisy_power,
    input  wire [fssf_pkg::PWR_W-1:0]  i_noise_power,
    input  wire                     i_last_bin,
    input  wire [fssf_pkg::GAIN_W-1:0] i_noise_epsilon,
    output logic                    o_push,
    output fssf_pkg::t_frame        o_frame
);
    import fssf_pkg::*;

    logic [SUM_W-1:0] r_noisy_sum, n_noisy_sum;
    logic [SUM_W-1:0] r_noise_sum, n_noise_sum;
    logic [SUM_W:0]   w_noisy_add, w_noise_add;
    logic [SUM_W-1:0] w_noisy_next, w_noise_next;
    logic             w_accept;

    assign w_accept     = i_valid & ~i_full;
    assign w_noisy_add  = {1'b0, r_noisy_sum} + {{(SUM_W+1-PWR_W){1'b0}}, i_noisy_power};
    assign w_noise_add  = {1'b0, r_noise_sum} + {{(SUM_W+1-PWR_W){1'b0}}, i_noise_power};
    assign w_noisy_next = w_noisy_add[SUM_W] ? SUM_MAX : w_noisy_add[SUM_W-1:0];
    assign w_noise_next = w_noise_add[SUM_W] ? SUM_MAX : w_noise_add[SUM_W-1:0];

    assign o_push       = w_accept & i_last_bin;
    assign o_frame.noisy = w_noisy_next;
    assign o_frame.den   = {1'b0, w_noise_next}
                         + {{(DEN_W-GAIN_W){1'b0}}, i_noise_epsilon};

    always_comb begin
        n_noisy_sum = r_noisy_sum;
        n_noise_sum = r_noise_sum;
        if (w_accept) begin
            if (i_last_bin) begin
                n_noisy_sum = '0;
                n_noise_sum = '0;
            end else begin
                n_noisy_sum = w_noisy_next;
                n_noise_sum = w_noise_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noisy_sum <= '0;
            r_noise_sum <= '0;
        end else begin
            r_noisy_sum <= n_noisy_sum;
            r_noise_sum <= n_noise_sum;
        end
    end

endmodule

`default_nettype wire

// File: src/fssf_queue.sv
// ============================================================================
// fssf_queue
// Two-entry queue of closed frame sums between the accumulator and the SNR
// engine.
// ============================================================================
`default_nettype none

module fssf_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  fssf_pkg::t_frame i_frame,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output fssf_pkg::t_frame o_frame
);
    import fssf_pkg::*;

    t_frame     r_entry [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_do_push, w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_frame   = r_entry[r_rp];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wp  = w_do_push ? ~r_wp : r_wp;
        n_rp  = w_do_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_do_push && w_do_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_entry[r_wp] <= i_frame;
        end
    end

endmodule

`default_nettype wire

// File: src/fssf_back.sv
// ============================================================================
// fssf_back
// SNR engine: shared normalizer and squaring log2 unit, dB scaling, the
// division by twenty and the blend of gains, with the output register.
// ============================================================================
`default_nettype none

module fssf_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  fssf_pkg::t_cfg             i_cfg,
    input  wire                        i_empty,
    input  fssf_pkg::t_frame           i_frame,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [fssf_pkg::GAIN_W-1:0] o_alpha_factor,
    output logic [fssf_pkg::GAIN_W-1:0] o_beta_factor
);
    import fssf_pkg::*;

    t_state              r_state, n_state;
    logic [DEN_W-1:0]    r_x, n_x;
    logic [DEN_W-1:0]    r_den, n_den;
    logic                r_sel, n_sel;
    logic [5:0]          r_k, n_k;
    logic [5:0]          r_msb, n_msb;
    logic [MANT_W-1:0]   r_m, n_m;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [3:0]          r_it, n_it;
    logic [LOG_W-1:0]    r_log_s, n_log_s;
    logic [LOG_W-1:0]    r_log_d, n_log_d;
    logic [SNR_W-1:0]    r_snr, n_snr;
    logic [GAIN_W-1:0]   r_t, n_t;
    logic [GAIN_W-1:0]   r_res_a, n_res_a;
    logic [GAIN_W-1:0]   r_res_b, n_res_b;
    logic                r_out_valid, n_out_valid;
    logic [GAIN_W-1:0]   r_out_a, n_out_a;
    logic [GAIN_W-1:0]   r_out_b, n_out_b;

    logic [2*MANT_W-1:0] w_sq;
    logic [31:0]         w_sq_top;
    logic [FRAC_W-1:0]   w_frac_next;
    logic signed [LOG_W:0] w_diff;
    logic [39:0]         w_snr_prod;
    logic [38:0]         w_t_prod;
    logic [GAIN_W-1:0]   w_gain, w_floor;
    logic signed [GAIN_W:0]   w_delta;
    logic signed [2*GAIN_W+1:0] w_bprod;
    logic signed [2*GAIN_W+1:0] w_bround;
    logic signed [GAIN_W+1:0]   w_bout;

    assign w_sq        = {{MANT_W{1'b0}}, r_m} * {{MANT_W{1'b0}}, r_m};
    assign w_sq_top    = w_sq[61:30];
    assign w_frac_next = {r_frac[FRAC_W-2:0], w_sq_top[31]};

    assign w_diff      = $signed({1'b0, r_log_s}) - $signed({1'b0, r_log_d});
    assign w_snr_prod  = {18'd0, w_diff[LOG_W-1:0]} * {22'd0, DB_PER_LOG2};
    assign w_t_prod    = {20'd0, r_snr[20:2]} * {19'd0, DIV5_MAGIC};

    assign w_gain   = (r_state == ST_BLEND_A) ? i_cfg.oversub_gain : i_cfg.undersub_gain;
    assign w_floor  = (r_state == ST_BLEND_A) ? i_cfg.alpha_floor : i_cfg.beta_floor;
    assign w_delta  = $signed({1'b0, w_floor}) - $signed({1'b0, w_gain});
    assign w_bprod  = $signed({1'b0, r_t}) * w_delta;
    assign w_bround = w_bprod + 34'sd32768;
    assign w_bout   = $signed({2'b00, w_gain}) + w_bround[33:16];

    assign o_valid        = r_out_valid;
    assign o_alpha_factor = r_out_a;
    assign o_beta_factor  = r_out_b;

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_den       = r_den;
        n_sel       = r_sel;
        n_k         = r_k;
        n_msb       = r_msb;
        n_m         = r_m;
        n_frac      = r_frac;
        n_it        = r_it;
        n_log_s     = r_log_s;
        n_log_d     = r_log_d;
        n_snr       = r_snr;
        n_t         = r_t;
        n_res_a     = r_res_a;
        n_res_b     = r_res_b;
        n_out_valid = r_out_valid;
        n_out_a     = r_out_a;
        n_out_b     = r_out_b;
        o_pop       = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cfg.scaling_mode) begin
                        n_res_a = i_cfg.alpha_floor;
                        n_res_b = i_cfg.beta_floor;
                        n_state = ST_DONE;
                    end else if (i_frame.noisy == '0) begin
                        n_res_a = i_cfg.oversub_gain;
                        n_res_b = i_cfg.undersub_gain;
                        n_state = ST_DONE;
                    end else if (i_frame.den == '0) begin
                        n_res_a = i_cfg.alpha_floor;
                        n_res_b = i_cfg.beta_floor;
                        n_state = ST_DONE;
                    end else begin
                        n_x     = {1'b0, i_frame.noisy};
                        n_den   = i_frame.den;
                        n_sel   = 1'b0;
                        n_k     = '0;
                        n_state = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (r_x[DEN_W-1]) begin
                    n_m     = r_x[DEN_W-1:DEN_W-MANT_W];
                    n_msb   = 6'(DEN_W - 1) - r_k;
                    n_frac  = '0;
                    n_it    = '0;
                    n_state = ST_LOG;
                end else begin
                    n_x = {r_x[DEN_W-2:0], 1'b0};
                    n_k = r_k + 6'd1;
                end
            end
            ST_LOG: begin
                n_frac = w_frac_next;
                n_m    = w_sq_top[31] ? w_sq_top[31:1] : w_sq_top[30:0];
                n_it   = r_it + 4'd1;
                if (r_it == 4'd15) begin
                    if (!r_sel) begin
                        n_log_s = {r_msb, w_frac_next};
                        n_x     = r_den;
                        n_sel   = 1'b1;
                        n_k     = '0;
                        n_state = ST_NORM;
                    end else begin
                        n_log_d = {r_msb, w_frac_next};
                        n_state = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                if (w_diff <= 0) begin
                    n_res_a = i_cfg.oversub_gain;
                    n_res_b = i_cfg.undersub_gain;
                    n_state = ST_DONE;
                end else begin
                    n_snr   = w_snr_prod[39:16];
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (r_snr == '0) begin
                    n_res_a = i_cfg.oversub_gain;
                    n_res_b = i_cfg.undersub_gain;
                    n_state = ST_DONE;
                end else if (r_snr >= TWENTY_DB) begin
                    n_res_a = i_cfg.alpha_floor;
                    n_res_b = i_cfg.beta_floor;
                    n_state = ST_DONE;
                end else begin
                    n_t     = w_t_prod[37:22];
                    n_state = ST_BLEND_A;
                end
            end
            ST_BLEND_A: begin
                n_res_a = w_bout[GAIN_W-1:0];
                n_state = ST_BLEND_B;
            end
            ST_BLEND_B: begin
                n_res_b = w_bout[GAIN_W-1:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_a     = r_res_a;
                    n_out_b     = r_res_b;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_den   <= n_den;
        r_sel   <= n_sel;
        r_k     <= n_k;
        r_msb   <= n_msb;
        r_m     <= n_m;
        r_frac  <= n_frac;
        r_it    <= n_it;
        r_log_s <= n_log_s;
        r_log_d <= n_log_d;
        r_snr   <= n_snr;
        r_t     <= n_t;
        r_res_a <= n_res_a;
        r_res_b <= n_res_b;
        r_out_a <= n_out_a;
        r_out_b <= n_out_b;
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking testbench of the frame SNR subtraction factors unit.
// ============================================================================
// A directed table covers the extremes of the bin powers, the zero noisy sum,
// the zero denominator, no-scaling mode and ignored register indexes; a long
// frame then saturates its noisy sum, and random frames run under several
// register settings and idle patterns. Every alpha/beta pair is compared with
// a table value or a Q.16 model of the frame SNR, log2 and blend arithmetic.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import fssf_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int SETTLE_CYCLES   = 140;
    localparam int RANDOM_BINS     = 128;
    localparam int PHASES          = 8;
    localparam int LONG_FRAME_BINS = 1028;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIR_ROWS        = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [GAIN_W-1:0] alpha;
        logic [GAIN_W-1:0] beta;
    } t_factors;

    typedef enum logic {ROW_BIN, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [GAIN_W-1:0]     data;
        logic [PWR_W-1:0]      noisy;
        logic [PWR_W-1:0]      noise;
        logic                  last;
        logic                  known;
        t_factors              want;
    } t_dir_row;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [PWR_W-1:0]     i_noisy_power = '0;
    logic [PWR_W-1:0]     i_noise_power = '0;
    logic                 i_last_bin    = 1'b0;
    logic                 i_out_stall   = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [GAIN_W-1:0]    i_cfg_data    = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [GAIN_W-1:0]    o_alpha_factor;
    logic [GAIN_W-1:0]    o_beta_factor;

    t_cfg             cfg_model = '{1'b0, 16'd512, 16'd256, 16'd256, 16'd0, 16'd1};
    logic [SUM_W-1:0] noisy_acc = '0;
    logic [SUM_W-1:0] noise_acc = '0;
    t_factors         factor_q[$];
    t_idle_mode       idle_mode = IDLE_NONE;
    int               errors = 0;
    int               pairs_checked = 0;
    int               bins_sent = 0;
    int               frames_sent = 0;
    int               reg_writes = 0;

    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0200_0100},
        '{ROW_BIN, 3'd0, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0100_0000},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0200_0100},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0001_0000, 32'h0000_FFFF, 1'b1, 1'b1, 32'h0200_0100},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h000A_0000, 32'h0000_FFFF, 1'b1, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0003_0000, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0005_0000, 32'h0001_0000, 1'b1, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h8000_0000, 32'h0000_1000, 1'b1, 1'b0, 32'h0},
        '{ROW_CFG, CFG_NOISE_EPSILON, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0007, 32'h0000_0000, 1'b1, 1'b1, 32'h0100_0000},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0200_0100},
        '{ROW_CFG, CFG_SCALING_MODE, 16'h0001, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0100_0000},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, 32'h0100_0000},
        '{ROW_CFG, CFG_SCALING_MODE, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0004_0000, 32'h0001_0000, 1'b1, 1'b0, 32'h0},
        '{ROW_CFG, CFG_OVERSUB_GAIN, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG, CFG_UNDERSUB_GAIN, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG, CFG_ALPHA_FLOOR, 16'h0000, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG, CFG_BETA_FLOOR, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG, CFG_NOISE_EPSILON, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0020_0000, 32'h0001_0000, 1'b1, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_BIN, 3'd0, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_FFFF},
        '{ROW_CFG, CFG_SPARE_LO, 16'h1234, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG, CFG_SPARE_HI, 16'hFFFF, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_BIN, 3'd0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF}
    };

    frame_snr_subtraction_factors_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_noisy_power  (i_noisy_power),
        .i_noise_power  (i_noise_power),
        .i_last_bin     (i_last_bin),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_alpha_factor (o_alpha_factor),
        .o_beta_factor  (o_beta_factor),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                 input logic [PWR_W-1:0] v);
        logic [63:0] s;
        s = 64'(acc) + 64'(v);
        return (s > 64'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // Leading-one index in the integer part, squaring of the mantissa for the
    // 16 fraction bits.
    function automatic longint octaves_q16(input logic [63:0] x);
        int          msb;
        int          k;
        logic [63:0] m;
        logic [15:0] frac;
        msb = 0;
        frac = '0;
        for (k = 0; k < 64; k++) begin
            if (x[k]) begin
                msb = k;
            end
        end
        m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
        for (k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h8000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (longint'(msb) << 16) + longint'(frac);
    endfunction

    function automatic logic [GAIN_W-1:0] mix_gain(input logic [GAIN_W-1:0] gain,
                                                   input logic [GAIN_W-1:0] floor_v,
                                                   input logic [63:0] t);
        logic [63:0] v;
        v = (64'd65536 - t) * 64'(gain) + t * 64'(floor_v) + 64'd32768;
        return v[31:16];
    endfunction

    function automatic t_factors frame_factors(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W-1:0] nsum);
        logic [63:0] den;
        longint      diff;
        longint      snr;
        logic [63:0] t;
        t_factors    gains;
        t_factors    floors;
        den = 64'(nsum) + 64'(cfg_model.noise_epsilon);
        gains = '{cfg_model.oversub_gain, cfg_model.undersub_gain};
        floors = '{cfg_model.alpha_floor, cfg_model.beta_floor};
        if (cfg_model.scaling_mode) begin
            return floors;
        end
        if (s == '0) begin
            return gains;
        end
        if (den == '0) begin
            return floors;
        end
        diff = octaves_q16(64'(s)) - octaves_q16(den);
        if (diff <= 0) begin
            return gains;
        end
        snr = (diff * longint'(DB_PER_LOG2)) >>> 16;
        if (snr <= 0) begin
            return gains;
        end
        if (snr >= longint'(TWENTY_DB)) begin
            return floors;
        end
        t = 64'(snr / 20);
        return '{mix_gain(cfg_model.oversub_gain, cfg_model.alpha_floor, t),
                 mix_gain(cfg_model.undersub_gain, cfg_model.beta_floor, t)};
    endfunction

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 58;
            IDLE_BOTH:   return $urandom_range(0, 99) < 18;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic send_bin(input logic [PWR_W-1:0] noisy, input logic [PWR_W-1:0] noise,
                            input logic last, input logic known, input t_factors lit);
        logic     stalled;
        t_factors want;
        while (sender_waits()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_noisy_power <= noisy;
        i_noise_power <= noise;
        i_last_bin    <= last;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        noisy_acc = sat_sum(noisy_acc, noisy);
        noise_acc = sat_sum(noise_acc, noise);
        bins_sent++;
        if (last) begin
            want = known ? lit : frame_factors(noisy_acc, noise_acc);
            factor_q.push_back(want);
            noisy_acc = '0;
            noise_acc = '0;
            frames_sent++;
        end
    endtask

    task automatic settle(input int extra);
        i_in_valid <= 1'b0;
        while (factor_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SCALING_MODE:  cfg_model.scaling_mode  = data[0];
            CFG_OVERSUB_GAIN:  cfg_model.oversub_gain  = data;
            CFG_UNDERSUB_GAIN: cfg_model.undersub_gain = data;
            CFG_ALPHA_FLOOR:   cfg_model.alpha_floor   = data;
            CFG_BETA_FLOOR:    cfg_model.beta_floor    = data;
            CFG_NOISE_EPSILON: cfg_model.noise_epsilon = data;
            default: ;
        endcase
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PWR_W-1:0] scaled_draw(input int bits);
        logic [63:0] r;
        r = 64'($urandom);
        return PWR_W'(r >> (32 - bits));
    endfunction

    // Noisy and noise magnitudes are drawn per frame so that the SNR lands
    // mostly around the blend region, with some frames far on either side.
    task automatic send_frame(input int len);
        int               nb;
        int               sb;
        int               k;
        logic [PWR_W-1:0] noisy;
        logic [PWR_W-1:0] noise;
        nb = $urandom_range(0, 32);
        if ($urandom_range(0, 3) == 0) begin
            sb = $urandom_range(0, 32);
        end else begin
            sb = nb + $urandom_range(0, 8);
            if (sb > 32) begin
                sb = 32;
            end
        end
        for (k = 1; k <= len; k++) begin
            noisy = scaled_draw(sb);
            noise = scaled_draw(nb);
            if ($urandom_range(0, 15) == 0) begin
                noisy = ($urandom_range(0, 1) != 0) ? '1 : '0;
            end
            send_bin(noisy, noise, k == len, 1'b0, '0);
        end
    endtask

    function automatic t_cfg phase_setting(input int phase);
        t_cfg c;
        c.scaling_mode  = ($urandom_range(0, 7) == 0);
        c.oversub_gain  = GAIN_W'($urandom);
        c.undersub_gain = GAIN_W'($urandom);
        c.alpha_floor   = GAIN_W'($urandom);
        c.beta_floor    = GAIN_W'($urandom);
        c.noise_epsilon = ($urandom_range(0, 2) == 0) ? GAIN_W'($urandom)
                                                      : GAIN_W'($urandom_range(0, 16));
        case (phase)
            0: c = '{1'b0, 16'd512, 16'd256, 16'd256, 16'd0, 16'd1};
            1: c = '0;
            2: c = '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3: c.scaling_mode = 1'b1;
            default: ;
        endcase
        return c;
    endfunction

    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_out_stall <= ($urandom_range(0, 99) < 58);
            IDLE_BOTH:     i_out_stall <= ($urandom_range(0, 99) < 18);
            default:       i_out_stall <= 1'b0;
        endcase
    end

    // Inputs only change at rising edges, so a transaction seen at the falling
    // edge is the one taken at the next rising edge.
    always @(negedge i_clk) begin : check_factors
        t_factors want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pairs_checked++;
            if (factor_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("tb_top: unexpected factor pair alpha %h beta %h",
                             o_alpha_factor, o_beta_factor);
                end
            end else begin
                want = factor_q.pop_front();
                if (o_alpha_factor !== want.alpha || o_beta_factor !== want.beta) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("tb_top: pair %0d alpha exp %h got %h, beta exp %h got %h",
                                 pairs_checked, want.alpha, o_alpha_factor,
                                 want.beta, o_beta_factor);
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        int   r;
        int   k;
        int   phase;
        int   phase_bins;
        int   len;
        t_cfg pick;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_mode = IDLE_BOTH;
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                settle(SETTLE_CYCLES);
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                send_bin(dir_rows[r].noisy, dir_rows[r].noise, dir_rows[r].last,
                         dir_rows[r].known, dir_rows[r].want);
            end
        end

        // One frame of LONG_FRAME_BINS full-scale bins: the noisy sum saturates, the
        // noise sum does not, so the result still depends on the clamped value.
        for (k = 1; k <= LONG_FRAME_BINS; k++) begin
            send_bin(32'hFFFF_FFFF, 32'h1800_0000, k == LONG_FRAME_BINS, 1'b0, '0);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            settle(SETTLE_CYCLES);
            idle_mode = t_idle_mode'(phase % 4);
            pick = phase_setting(phase);
            cfg_write(CFG_SCALING_MODE, GAIN_W'(pick.scaling_mode));
            cfg_write(CFG_OVERSUB_GAIN, pick.oversub_gain);
            cfg_write(CFG_UNDERSUB_GAIN, pick.undersub_gain);
            cfg_write(CFG_ALPHA_FLOOR, pick.alpha_floor);
            cfg_write(CFG_BETA_FLOOR, pick.beta_floor);
            cfg_write(CFG_NOISE_EPSILON, pick.noise_epsilon);
            phase_bins = 0;
            while (phase_bins < RANDOM_BINS / PHASES) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16);
                if ($urandom_range(0, 15) == 0) begin
                    settle(0);
                end
                send_frame(len);
                phase_bins += len;
            end
        end

        settle(SETTLE_CYCLES);
        if (factor_q.size() != 0) begin
            errors += factor_q.size();
        end
        $display("tb_top: %0d bins in %0d frames, %0d register writes, %0d pairs compared",
                 bins_sent, frames_sent, reg_writes, pairs_checked);
        $display("tb_top: %0d mismatching or unexpected pairs", errors);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
